### sv/duplicate_element_finder_macros.svh
// Assertion macros shared by the duplicate element finder RTL.
`ifndef DUPLICATE_ELEMENT_FINDER_MACROS_SVH
`define DUPLICATE_ELEMENT_FINDER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define DUPF_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define DUPF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### sv/dupf_pkg.sv
// Package with shared types and constants of the duplicate element finder.
package dupf_pkg;

    localparam int VALUE_W          = 32;
    localparam int MAX_ELEMENTS_DEF = 64;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN_RD,
        S_SCAN_CHK,
        S_STORE,
        S_OUT_RD,
        S_OUT_CHK,
        S_OUT_FIN
    } state_t;

endpackage

### sv/duplicate_element_finder.sv
// Duplicate element finder: stores a list and reports elements repeated later.
// Each element is compared against every stored element and then stored; a full store drops it.
// The last element then starts an output sweep over the stored elements.
// Throughput: one item at a time; the single read port of the element memory sets the pace.
// Results leave through an output register, so the sweep stalls only when it is still full.
// Reset (rst_n, asynchronous, active low) empties the list and clears the output valid flag.
`include "duplicate_element_finder_macros.svh"

module duplicate_element_finder #(
    parameter int MAX_ELEMENTS = dupf_pkg::MAX_ELEMENTS_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic signed [dupf_pkg::VALUE_W-1:0]  element_value,
    input  logic                                 last_element,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic signed [dupf_pkg::VALUE_W-1:0]  dup_value,
    output logic                                 last_result,
    output logic                                 list_empty,
    output logic                                 overflow
);

    import dupf_pkg::*;

    localparam int AW = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
    localparam int CW = $clog2(MAX_ELEMENTS + 1);
    localparam int EW = VALUE_W + 1;

    // Each entry holds the seen-later flag above the element value.
    logic [EW-1:0] mem [MAX_ELEMENTS];
    logic [EW-1:0] rd_data_reg;
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [EW-1:0] wr_data;

    state_t state_reg, state_next;

    logic [CW-1:0]      count_reg, count_next;
    logic [AW-1:0]      idx_reg, idx_next;
    logic               ovf_reg, ovf_next;
    logic [VALUE_W-1:0] item_reg, item_next;
    logic               last_reg, last_next;
    logic               pend_valid_reg, pend_valid_next;
    logic [VALUE_W-1:0] pend_reg, pend_next;

    logic               out_valid_reg, out_valid_next;
    logic [VALUE_W-1:0] out_value_reg, out_value_next;
    logic               out_last_reg, out_last_next;
    logic               out_empty_reg, out_empty_next;
    logic               out_ovf_reg, out_ovf_next;

    logic accept;
    logic full;
    logic out_free;
    logic idx_at_end;
    logic hit;
    logic flag;
    logic out_stall;

    assign accept     = in_valid && in_ready;
    assign full       = (count_reg == CW'(MAX_ELEMENTS));
    assign out_free   = !out_valid_reg || out_ready;
    assign idx_at_end = ((CW'(idx_reg) + CW'(1)) == count_reg);
    assign hit        = (rd_data_reg[VALUE_W-1:0] == item_reg);
    assign flag       = rd_data_reg[EW-1];
    assign out_stall  = flag && pend_valid_reg && !out_free;

    assign in_ready    = (state_reg == S_IDLE);
    assign out_valid   = out_valid_reg;
    assign dup_value   = $signed(out_value_reg);
    assign last_result = out_last_reg;
    assign list_empty  = out_empty_reg;
    assign overflow    = out_ovf_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (!full)
                    begin
                        state_next = (count_reg == '0) ? S_STORE : S_SCAN_RD;
                    end
                    else if (last_element)
                    begin
                        state_next = S_OUT_RD;
                    end
                end
            end
            S_SCAN_RD:
            begin
                state_next = S_SCAN_CHK;
            end
            S_SCAN_CHK:
            begin
                state_next = idx_at_end ? S_STORE : S_SCAN_RD;
            end
            S_STORE:
            begin
                state_next = last_reg ? S_OUT_RD : S_IDLE;
            end
            S_OUT_RD:
            begin
                state_next = S_OUT_CHK;
            end
            S_OUT_CHK:
            begin
                if (!out_stall)
                begin
                    state_next = idx_at_end ? S_OUT_FIN : S_OUT_RD;
                end
            end
            S_OUT_FIN:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        rd_en           = 1'b0;
        rd_addr         = idx_reg;
        wr_en           = 1'b0;
        wr_addr         = idx_reg;
        wr_data         = {1'b1, item_reg};
        count_next      = count_reg;
        idx_next        = idx_reg;
        ovf_next        = ovf_reg;
        item_next       = item_reg;
        last_next       = last_reg;
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        out_value_next  = out_value_reg;
        out_last_next   = out_last_reg;
        out_empty_next  = out_empty_reg;
        out_ovf_next    = out_ovf_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    item_next = $unsigned(element_value);
                    last_next = last_element;
                    idx_next  = '0;
                    if (full)
                    begin
                        ovf_next = 1'b1;
                    end
                end
            end
            S_SCAN_RD, S_OUT_RD:
            begin
                rd_en = 1'b1;
            end
            S_SCAN_CHK:
            begin
                wr_en    = hit;
                idx_next = idx_reg + AW'(1);
            end
            S_STORE:
            begin
                wr_en      = 1'b1;
                wr_addr    = count_reg[AW-1:0];
                wr_data    = {1'b0, item_reg};
                count_next = count_reg + CW'(1);
                idx_next   = '0;
            end
            S_OUT_CHK:
            begin
                if (!out_stall)
                begin
                    idx_next = idx_reg + AW'(1);
                    if (flag)
                    begin
                        if (pend_valid_reg)
                        begin
                            out_valid_next = 1'b1;
                            out_value_next = pend_reg;
                            out_last_next  = 1'b0;
                            out_empty_next = 1'b0;
                            out_ovf_next   = ovf_reg;
                        end
                        pend_next       = rd_data_reg[VALUE_W-1:0];
                        pend_valid_next = 1'b1;
                    end
                end
            end
            S_OUT_FIN:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_value_next  = pend_valid_reg ? pend_reg : '0;
                    out_last_next   = 1'b1;
                    out_empty_next  = !pend_valid_reg;
                    out_ovf_next    = ovf_reg;
                    count_next      = '0;
                    ovf_next        = 1'b0;
                    pend_valid_next = 1'b0;
                end
            end
            default:
            begin
                rd_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            count_reg      <= '0;
            idx_reg        <= '0;
            ovf_reg        <= 1'b0;
            last_reg       <= 1'b0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            idx_reg        <= idx_next;
            ovf_reg        <= ovf_next;
            last_reg       <= last_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg      <= item_next;
        pend_reg      <= pend_next;
        out_value_reg <= out_value_next;
        out_last_reg  <= out_last_next;
        out_empty_reg <= out_empty_next;
        out_ovf_reg   <= out_ovf_next;
    end

    `DUPF_ASSERT_NOW(a_count_bound, 1'b1, count_reg <= CW'(MAX_ELEMENTS), "element count above capacity")
    `DUPF_ASSERT_NOW(a_empty_form, out_valid_reg && out_empty_reg, out_last_reg && (out_value_reg == '0), "empty result malformed")
    `DUPF_ASSERT_NOW(a_write_state, wr_en, (state_reg == S_SCAN_CHK) || (state_reg == S_STORE), "memory write outside load")
    `DUPF_ASSERT_NOW(a_pend_state, pend_valid_reg, (state_reg == S_OUT_RD) || (state_reg == S_OUT_CHK) || (state_reg == S_OUT_FIN), "pending result outside sweep")
    `DUPF_ASSERT_NEXT(a_fin_clears, (state_reg == S_OUT_FIN) && out_free, (count_reg == '0) && !ovf_reg && out_valid_reg && out_last_reg, "list not closed after final result")

endmodule

### tb/tb_duplicate_element_finder.sv
// Self-checking testbench for the duplicate element finder with its own duplicate predictor.
`timescale 1ns / 1ps

module tb_duplicate_element_finder;

    localparam int VALUE_W     = dupf_pkg::VALUE_W;
    localparam int CAPACITY    = dupf_pkg::MAX_ELEMENTS_DEF;
    localparam int ITEM_TARGET = 330;
    localparam int CYCLE_LIMIT = 400000;

    localparam logic signed [VALUE_W-1:0] MOST_NEG = {1'b1, {(VALUE_W-1){1'b0}}};
    localparam logic signed [VALUE_W-1:0] MOST_POS = {1'b0, {(VALUE_W-1){1'b1}}};

    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic                      is_last;
        logic                      is_empty;
        logic                      ovf;
    } dup_report_t;

    logic                      clk;
    logic                      rst_n;
    logic                      in_valid;
    logic                      in_ready;
    logic signed [VALUE_W-1:0] element_value;
    logic                      last_element;
    logic                      out_valid;
    logic                      out_ready;
    logic signed [VALUE_W-1:0] dup_value;
    logic                      last_result;
    logic                      list_empty;
    logic                      overflow;

    logic signed [VALUE_W-1:0] stored_vals [CAPACITY];
    bit                        later_seen [CAPACITY];
    int                        stored_count;
    bit                        dropped;
    dup_report_t               dup_report_q[$];

    int error_count;
    int items_sent;
    int hold_cycles;
    bit no_idle;

    duplicate_element_finder i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .element_value (element_value),
        .last_element  (last_element),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .dup_value     (dup_value),
        .last_result   (last_result),
        .list_empty    (list_empty),
        .overflow      (overflow)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #2 clk = ~clk;
        end
    end

    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("Verification failed");
        $finish;
    end

    // Receiver: random stalls unless no_idle is set, plus a long hold-off whenever one is requested.
    initial
    begin
        out_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_cycles > 0)
            begin
                out_ready <= 1'b0;
                hold_cycles--;
            end
            else if (no_idle)
            begin
                out_ready <= 1'b1;
            end
            else
            begin
                out_ready <= ($urandom_range(99) >= 13);
            end
        end
    end

    always @(posedge clk)
    begin : result_check
        dup_report_t exp;
        if (rst_n && out_valid && out_ready)
        begin
            if (dup_report_q.size() == 0)
            begin
                $display("%0t: unexpected result, got dup_value %0d last %0b empty %0b ovf %0b",
                         $time, dup_value, last_result, list_empty, overflow);
                error_count++;
            end
            else
            begin
                exp = dup_report_q.pop_front();
                if (dup_value !== exp.value)
                begin
                    $display("%0t: dup_value mismatch, expected %0d, got %0d",
                             $time, exp.value, dup_value);
                    error_count++;
                end
                if (last_result !== exp.is_last)
                begin
                    $display("%0t: last_result mismatch, expected %0b, got %0b",
                             $time, exp.is_last, last_result);
                    error_count++;
                end
                if (list_empty !== exp.is_empty)
                begin
                    $display("%0t: list_empty mismatch, expected %0b, got %0b",
                             $time, exp.is_empty, list_empty);
                    error_count++;
                end
                if (overflow !== exp.ovf)
                begin
                    $display("%0t: overflow mismatch, expected %0b, got %0b",
                             $time, exp.ovf, overflow);
                    error_count++;
                end
            end
        end
    end

    function automatic void track_element(input logic signed [VALUE_W-1:0] v,
                                          input logic last);
        int total;
        int k;
        dup_report_t r;
        if (stored_count < CAPACITY)
        begin
            for (int i = 0; i < stored_count; i++)
            begin
                if (stored_vals[i] == v)
                    later_seen[i] = 1'b1;
            end
            stored_vals[stored_count] = v;
            later_seen[stored_count] = 1'b0;
            stored_count++;
        end
        else
        begin
            dropped = 1'b1;
        end
        if (last)
        begin
            total = 0;
            for (int i = 0; i < stored_count; i++)
            begin
                if (later_seen[i])
                    total++;
            end
            k = 0;
            for (int i = 0; i < stored_count; i++)
            begin
                if (later_seen[i])
                begin
                    r = '{stored_vals[i], (k == total - 1), 1'b0, dropped};
                    dup_report_q.push_back(r);
                    k++;
                end
            end
            if (total == 0)
            begin
                r = '{'0, 1'b1, 1'b1, dropped};
                dup_report_q.push_back(r);
            end
            for (int i = 0; i < CAPACITY; i++)
                later_seen[i] = 1'b0;
            stored_count = 0;
            dropped = 1'b0;
        end
    endfunction

    task automatic send_element(input logic signed [VALUE_W-1:0] v, input logic last);
        in_valid      <= 1'b1;
        element_value <= v;
        last_element  <= last;
        do
            @(posedge clk);
        while (!in_ready);
        track_element(v, last);
        items_sent++;
        if (!no_idle && $urandom_range(99) < 13)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
    endtask

    task automatic send_random_list(input int len, input int pool_size);
        logic signed [VALUE_W-1:0] pool [$];
        int pick;
        for (int i = 0; i < pool_size; i++)
        begin
            pick = $urandom_range(9);
            if (pick == 0)
                pool.push_back(MOST_NEG);
            else if (pick == 1)
                pool.push_back(MOST_POS);
            else
                pool.push_back($urandom());
        end
        for (int i = 0; i < len; i++)
            send_element(pool[$urandom_range(pool_size - 1)], (i == len - 1));
    endtask

    task automatic test_single_element();
        send_element(32'sd7, 1'b1);
    endtask

    task automatic test_no_duplicates();
        send_element(MOST_NEG, 1'b0);
        send_element(MOST_POS, 1'b0);
        send_element('0, 1'b0);
        send_element(-32'sd1, 1'b1);
    endtask

    task automatic test_extreme_duplicates();
        send_element(MOST_NEG, 1'b0);
        send_element(MOST_POS, 1'b0);
        send_element(MOST_NEG, 1'b0);
        send_element(-32'sd1, 1'b0);
        send_element(MOST_POS, 1'b0);
        send_element('0, 1'b0);
        send_element(-32'sd1, 1'b0);
        send_element('0, 1'b0);
        send_element(MOST_NEG, 1'b1);
    endtask

    task automatic test_last_repeats();
        send_element(32'sd5, 1'b0);
        send_element(32'sd5, 1'b1);
        send_element(32'sh55555555, 1'b0);
        send_element(32'shAAAAAAAA, 1'b0);
        send_element(32'sh55555555, 1'b0);
        send_element(32'shAAAAAAAA, 1'b1);
    endtask

    // Every stored element but the last repeats later, so a full store yields the most results a list can.
    task automatic test_full_store();
        logic signed [VALUE_W-1:0] v;
        v = $urandom();
        for (int i = 0; i < CAPACITY; i++)
            send_element(v, (i == CAPACITY - 1));
    endtask

    task automatic test_overflow();
        send_random_list(CAPACITY + 3, 12);
        send_random_list(CAPACITY + 1, 1);
    endtask

    task automatic test_backpressure();
        hold_cycles = 500;
        send_random_list(40, 3);
        send_random_list(6, 2);
    endtask

    task automatic test_back_to_back();
        no_idle = 1'b1;
        for (int i = 0; i < 6; i++)
            send_random_list($urandom_range(1, 10), $urandom_range(1, 5));
        no_idle = 1'b0;
    endtask

    task automatic test_random_lists();
        int len;
        while (items_sent < ITEM_TARGET)
        begin
            if ($urandom_range(99) < 6)
                len = $urandom_range(CAPACITY - 4, CAPACITY + 6);
            else
                len = $urandom_range(1, 12);
            send_random_list(len, $urandom_range(1, 8));
        end
    endtask

    initial
    begin
        rst_n         <= 1'b0;
        in_valid      <= 1'b0;
        element_value <= '0;
        last_element  <= 1'b0;
        error_count   = 0;
        items_sent    = 0;
        hold_cycles   = 0;
        no_idle       = 1'b0;
        stored_count  = 0;
        dropped       = 1'b0;
        for (int i = 0; i < CAPACITY; i++)
            later_seen[i] = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_single_element();
        test_no_duplicates();
        test_extreme_duplicates();
        test_last_repeats();
        test_full_store();
        test_overflow();
        test_backpressure();
        test_back_to_back();
        test_random_lists();

        in_valid <= 1'b0;
        while (dup_report_q.size() != 0)
            @(posedge clk);
        repeat (2 * CAPACITY + 20) @(posedge clk);

        if (error_count == 0)
        begin
            $display("Verification passed");
        end
        else
        begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
